// ===== sv/stg_pkg.sv =====
// Shared types, constants and the sine table generator for the wave generator.
`default_nettype none
package stg_pkg;

    // Field widths
    localparam int unsigned PHASE_W  = 10;
    localparam int unsigned CODE_W   = 12;
    localparam int unsigned DAC_W    = 16;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned STEP_W   = 7;
    localparam int unsigned CFG_IDX_W = 2;

    // Control nibble of the DAC word
    localparam logic [3:0] CTRL_BITS = 4'h3;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_STEP       = 2'd0,
        REG_SAMPLE_INTERVAL = 2'd1,
        REG_PERIOD_TICKS    = 2'd2
    } stg_reg_t;

    // Reset values of the registers
    localparam logic [STEP_W-1:0] FREQ_STEP_RST       = 7'd1;
    localparam logic [CNT_W-1:0]  SAMPLE_INTERVAL_RST = 16'd44;
    localparam logic [CNT_W-1:0]  PERIOD_TICKS_RST    = 16'd30000;

    // Angle constants in Q30 radians
    localparam logic [63:0] ANG_STEP_Q30 = 64'd9864681;
    localparam logic [63:0] TWO_PI_Q30   = 64'd6746518852;
    localparam logic [63:0] PI_Q30       = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam logic [63:0] ONE_Q30      = 64'd1073741824;
    localparam logic [63:0] MID_CODE     = 64'd2047;
    localparam logic [63:0] MAX_CODE     = 64'd4095;

    // Taylor series divisors 2k(2k+1) for k = 1..6
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

    // Sample request from the counter logic to the table read
    typedef struct packed {
        logic               fire;
        logic [PHASE_W-1:0] phase;
    } stg_sample_t;

    // Sine code of table entry x, evaluated at elaboration only
    function automatic logic [CODE_W-1:0] stg_rom_code(input int unsigned x);
        logic [63:0] a;
        logic [63:0] m2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] p;
        logic [63:0] code;
        longint      sum;
        logic        neg;
        a   = 64'(x) * ANG_STEP_Q30;
        neg = 1'b0;
        // Reduce to one turn; one subtraction covers the index range
        if (a >= TWO_PI_Q30)
            a = a - TWO_PI_Q30;
        if (a > PI_Q30)
        begin
            a   = TWO_PI_Q30 - a;
            neg = 1'b1;
        end
        if (a > HALF_PI_Q30)
            a = PI_Q30 - a;
        m2   = (a * a) >> 30;
        term = a;
        sum  = longint'(a);
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * m2) >> 30) / TAYLOR_DIV[k-1];
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        s = 64'(sum);
        if (s > ONE_Q30)
            s = ONE_Q30;
        p = MID_CODE * s;
        if (neg)
            code = MID_CODE - ((p + (ONE_Q30 - 64'd1)) >> 30);
        else
            code = MID_CODE + (p >> 30);
        if (code > MAX_CODE)
            code = MAX_CODE;
        return code[CODE_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== sv/stg_ctrl.sv =====
// Configuration registers, sample and period counters and the phase index.
`default_nettype none
module stg_ctrl
    import stg_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 682
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data,
    input  wire logic                 tick_en,
    output stg_sample_t               sample
);

    logic [STEP_W-1:0]  freq_step_reg;
    logic [CNT_W-1:0]   sample_interval_reg;
    logic [CNT_W-1:0]   period_ticks_reg;
    logic [CNT_W-1:0]   sample_cnt_reg, sample_cnt_next;
    logic [CNT_W-1:0]   period_cnt_reg, period_cnt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W:0]     sample_inc;
    logic [CNT_W:0]     period_inc;
    logic [PHASE_W:0]   phase_sum;
    logic [PHASE_W-1:0] phase_adv;
    logic               sample_fire;
    logic               period_fire;

    // Write configuration registers; unknown index is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_step_reg       <= FREQ_STEP_RST;
            sample_interval_reg <= SAMPLE_INTERVAL_RST;
            period_ticks_reg    <= PERIOD_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (stg_reg_t'(cfg_index))
                REG_FREQ_STEP:       freq_step_reg       <= cfg_data[STEP_W-1:0];
                REG_SAMPLE_INTERVAL: sample_interval_reg <= cfg_data;
                REG_PERIOD_TICKS:    period_ticks_reg    <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Fire tests; a zero interval fires on every tick
    assign sample_inc  = {1'b0, sample_cnt_reg} + (CNT_W+1)'(1);
    assign period_inc  = {1'b0, period_cnt_reg} + (CNT_W+1)'(1);
    assign sample_fire = sample_inc >= {1'b0, sample_interval_reg};
    assign period_fire = period_inc >= {1'b0, period_ticks_reg};

    // Advance phase and wrap at the table depth; on a short table the step
    // can pass the end twice
    assign phase_sum = {1'b0, phase_reg} + (PHASE_W+1)'(freq_step_reg);
    assign phase_adv = ({1'b0, phase_sum} >= (PHASE_W+2)'(2 * TABLE_DEPTH))
                     ? PHASE_W'(phase_sum - (PHASE_W+1)'(2 * TABLE_DEPTH))
                     : (phase_sum >= (PHASE_W+1)'(TABLE_DEPTH))
                     ? PHASE_W'(phase_sum - (PHASE_W+1)'(TABLE_DEPTH))
                     : phase_sum[PHASE_W-1:0];

    // Next counter and phase values; period reset follows the sample
    always_comb
    begin
        sample_cnt_next = sample_cnt_reg;
        period_cnt_next = period_cnt_reg;
        phase_next      = phase_reg;
        if (tick_en)
        begin
            if (sample_fire)
            begin
                sample_cnt_next = '0;
                phase_next      = phase_adv;
            end
            else
                sample_cnt_next = sample_inc[CNT_W-1:0];
            if (period_fire)
            begin
                period_cnt_next = '0;
                phase_next      = '0;
            end
            else
                period_cnt_next = period_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_cnt_reg <= '0;
            period_cnt_reg <= '0;
            phase_reg      <= PHASE_W'(1);
        end
        else
        begin
            sample_cnt_reg <= sample_cnt_next;
            period_cnt_reg <= period_cnt_next;
            phase_reg      <= phase_next;
        end
    end

    // Sample request for this tick
    assign sample.fire  = tick_en & sample_fire;
    assign sample.phase = phase_adv;

endmodule
`default_nettype wire

// ===== sv/stg_rom.sv =====
// Fixed sine code table with a registered read port.
`default_nettype none
module stg_rom
    import stg_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 682
)
(
    input  wire logic               clk,
    input  wire logic               rd_en,
    input  wire logic [PHASE_W-1:0] rd_addr,
    output logic      [CODE_W-1:0]  rd_data
);

    localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

    logic [CODE_W-1:0] rom_mem [TABLE_DEPTH];
    logic [CODE_W-1:0] rd_data_reg;

    // Fill table contents at elaboration
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_rom
        assign rom_mem[i] = stg_rom_code(i);
    end

    // Read on request, hold otherwise
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= rom_mem[rd_addr[ADDR_W-1:0]];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== sv/sine_table_wave_generator_unit.sv =====
// Sine table wave generator: counters, table read stage and output register.
// A sample passes the table read stage and the output register before it leaves on m_tvalid.
// Throughput: one tick item per cycle while the output is not stalled; the table read and
// the output register run overlapped.
// Reset (rst_n low, asynchronous): counters 0, phase 1, registers to their defaults,
// no sample pending.
`default_nettype none
module sine_table_wave_generator_unit
    import stg_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 682
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [0] tick, [7:1] zero
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [31:0]          m_tdata,   // [15:0] dac_word, [25:16] phase_at_sample
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CNT_W-1:0]     cfg_data
);

    stg_sample_t        sample;
    logic               in_accept;
    logic               tick_en;
    logic               rd_en;
    logic [CODE_W-1:0]  rd_data;
    logic               s1_valid_reg, s1_valid_next;
    logic [PHASE_W-1:0] s1_phase_reg;
    logic               s1_move;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;

    assign cfg_ready = 1'b1;

    // Take an item whenever the read stage is free or drains this cycle
    assign s1_move   = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || s1_move;
    assign in_accept = s_tvalid && s_tready;
    assign tick_en   = in_accept && s_tdata[0];

    stg_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick_en   (tick_en),
        .sample    (sample)
    );

    assign rd_en = sample.fire;

    stg_rom #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_rom (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (sample.phase),
        .rd_data (rd_data)
    );

    // Read stage: load on a sample, drop when passed on
    always_comb
    begin
        priority if (rd_en)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            s1_phase_reg <= sample.phase;
    end

    // Output register: advance when empty or taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
            out_data_reg <= {6'd0, s1_phase_reg, CTRL_BITS, rd_data};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A sample request always lands in the read stage
    a_sample_loads: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> s1_valid_reg)
        else $error("sample request lost before read stage");

    // Never accept a tick while the read stage is full and stalled
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_move) |-> !in_accept)
        else $error("item accepted over a stalled read stage");

    // Emitted phase stays inside the table
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[25:16]} < (PHASE_W+1)'(TABLE_DEPTH)))
        else $error("phase_at_sample beyond table depth");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_sine_table_wave_generator_unit.sv =====
// Self-checking testbench for the sine table wave generator: tick driver, sample checker, predictor.
`timescale 1ns / 100ps
module tb_sine_table_wave_generator_unit;
    import stg_pkg::*;

    localparam int unsigned DEPTH       = 682;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned PHASE_TICKS = 100;

    // Unused register slot, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // Angle constants in Q30 radians and the DAC control nibble
    localparam longint unsigned ANGLE_INC    = 64'd9864681;
    localparam longint unsigned FULL_TURN    = 64'd6746518852;
    localparam longint unsigned HALF_TURN    = 64'd3373259426;
    localparam longint unsigned QUARTER_TURN = 64'd1686629713;
    localparam longint unsigned UNIT_Q30     = 64'd1073741824;
    localparam longint unsigned SINE_MID     = 64'd2047;
    localparam longint unsigned SINE_TOP     = 64'd4095;
    localparam logic [3:0]      DAC_CTRL     = 4'h3;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [DAC_W-1:0]   dac;
    } sample_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'd0;   // [0] tick, [7:1] zero
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;            // [15:0] dac_word, [25:16] phase_at_sample
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FREQ_STEP;
    logic [CNT_W-1:0]     cfg_data  = '0;

    // Predictor copy of the registers and counters
    logic [STEP_W-1:0]  cur_step     = FREQ_STEP_RST;
    logic [CNT_W-1:0]   sample_gap   = SAMPLE_INTERVAL_RST;
    logic [CNT_W-1:0]   reset_gap    = PERIOD_TICKS_RST;
    logic [CNT_W-1:0]   sample_count = '0;
    logic [CNT_W-1:0]   period_count = '0;
    logic [PHASE_W-1:0] phase_pos    = 10'd1;
    logic [CODE_W-1:0]  sine_codes [DEPTH];

    logic    pending_ticks [$];
    sample_t expected_samples [$];

    int unsigned send_idle_pct = 11;
    int unsigned recv_idle_pct = 58;
    int unsigned hold_reqs     = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned stall_cycles  = 0;
    int unsigned failures      = 0;

    sine_table_wave_generator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sine code of one table entry: fold the angle into the first quadrant,
    // then a seven-term Taylor series in Q30
    function automatic logic [CODE_W-1:0] sine_code(input int unsigned x);
        longint unsigned ang;
        longint unsigned sq;
        longint unsigned term;
        longint unsigned mag;
        longint unsigned prod;
        longint unsigned code;
        longint          acc;
        bit              neg;
        int unsigned     k;
        ang = (longint'(x) * ANGLE_INC) % FULL_TURN;
        neg = 1'b0;
        if (ang > HALF_TURN)
        begin
            ang = FULL_TURN - ang;
            neg = 1'b1;
        end
        if (ang > QUARTER_TURN)
            ang = HALF_TURN - ang;
        sq   = (ang * ang) >> 30;
        term = ang;
        acc  = longint'(ang);
        for (k = 1; k <= 6; k++)
        begin
            term = ((term * sq) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        mag = longint'(acc);
        if (mag > UNIT_Q30)
            mag = UNIT_Q30;
        prod = SINE_MID * mag;
        if (neg)
            code = SINE_MID - ((prod + UNIT_Q30 - 1) >> 30);
        else
            code = SINE_MID + (prod >> 30);
        if (code > SINE_TOP)
            code = SINE_TOP;
        return code[CODE_W-1:0];
    endfunction

    // Advance counters and phase for one accepted tick; queue the sample it emits
    task automatic predict_tick(input logic tick);
        sample_t s;
        if (!tick)
            return;
        if (32'(sample_count) + 32'd1 >= 32'(sample_gap))
        begin
            sample_count = '0;
            phase_pos    = PHASE_W'((32'(phase_pos) % DEPTH + 32'(cur_step)) % DEPTH);
            s.phase      = phase_pos;
            s.dac        = {DAC_CTRL, sine_codes[phase_pos]};
            expected_samples.push_back(s);
        end
        else
            sample_count = sample_count + 1'b1;
        if (32'(period_count) + 32'd1 >= 32'(reset_gap))
        begin
            period_count = '0;
            phase_pos    = '0;
        end
        else
            period_count = period_count + 1'b1;
    endtask

    // Tick driver: predict on acceptance, then offer the next pending item
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                predict_tick(s_tdata[0]);
            if (!s_tvalid || s_tready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, pending_ticks.pop_front()};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Sample receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_seen != hold_reqs)
        begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Sample checker: compare each accepted item with the oldest prediction
    always @(posedge clk)
    begin
        sample_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("unexpected sample: m_tdata %h", m_tdata);
                failures = failures + 1;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (m_tdata[15:0] !== want.dac)
                begin
                    $error("dac_word: expected %h, got %h", want.dac, m_tdata[15:0]);
                    failures = failures + 1;
                end
                if (m_tdata[25:16] !== want.phase)
                begin
                    $error("phase_at_sample: expected %0d, got %0d", want.phase,
                           m_tdata[25:16]);
                    failures = failures + 1;
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves an item for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("tb_sine_table_wave_generator_unit NOT OK");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FREQ_STEP:       cur_step   = val[STEP_W-1:0];
            REG_SAMPLE_INTERVAL: sample_gap = val;
            REG_PERIOD_TICKS:    reset_gap  = val;
            default:             ;
        endcase
    endtask

    // Wait until every tick is taken and every sample has arrived, then let the pipe drain
    task automatic settle();
        @(negedge clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Queue a run of ticks; zero_pct of them carry a zero tick
    task automatic feed(input int unsigned n, input int unsigned zero_pct);
        int unsigned i;
        @(negedge clk);
        for (i = 0; i < n; i++)
            pending_ticks.push_back($urandom_range(99, 0) >= zero_pct);
    endtask

    task automatic feed_pattern(input logic [15:0] pattern, input int unsigned n);
        int unsigned i;
        @(negedge clk);
        for (i = 0; i < n; i++)
            pending_ticks.push_back(pattern[i]);
    endtask

    initial
    begin
        int unsigned     x;
        int unsigned     ph;
        int unsigned     sel;
        logic [CNT_W-1:0] val;
        for (x = 0; x < DEPTH; x++)
            sine_codes[x] = sine_code(x);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: two samples at interval 44
        feed(90, 0);
        settle();

        // Zero interval, zero step holding the phase, a zero tick, short period
        write_reg(REG_SAMPLE_INTERVAL, 16'd0);
        write_reg(REG_PERIOD_TICKS, 16'd4);
        write_reg(REG_FREQ_STEP, 16'd0);
        feed_pattern(16'b111011, 6);
        settle();

        // Upper data bits dropped on the step; zero period resets every tick
        write_reg(REG_FREQ_STEP, 16'hFFFF);
        write_reg(REG_PERIOD_TICKS, 16'd0);
        feed(4, 0);
        settle();

        // Largest step with a long period: phase wraps past the table end
        write_reg(REG_PERIOD_TICKS, 16'hFFFF);
        feed(7, 0);
        settle();

        // Longest interval, spare register write, then interval lowered below the count
        write_reg(REG_FREQ_STEP, 16'd64);
        write_reg(REG_SAMPLE_INTERVAL, 16'hFFFF);
        write_reg(REG_SPARE, 16'h5A5A);
        feed(4, 0);
        settle();
        write_reg(REG_SAMPLE_INTERVAL, 16'd2);
        feed(3, 0);
        settle();

        // Random phases over three idling patterns
        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == PHASES / 3)
            begin
                send_idle_pct = 58;
                recv_idle_pct = 11;
            end
            else if (ph == 2 * PHASES / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (ph < 3 || $urandom_range(3, 0) != 0)
            begin
                sel = $urandom_range(3, 0);
                val = (sel == 0) ? 16'd1 : (sel == 1) ? 16'd64 :
                      (sel == 2) ? 16'($urandom_range(127, 0)) : 16'($urandom);
                write_reg(REG_FREQ_STEP, val);
            end
            if (ph < 3 || $urandom_range(3, 0) != 0)
            begin
                sel = $urandom_range(9, 0);
                val = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                      (sel == 2) ? 16'($urandom) : 16'($urandom_range(12, 1));
                if (ph == 6)
                    val = 16'd1;
                write_reg(REG_SAMPLE_INTERVAL, val);
            end
            else if (ph == 6)
                write_reg(REG_SAMPLE_INTERVAL, 16'd1);
            if (ph < 3 || $urandom_range(3, 0) != 0)
            begin
                sel = $urandom_range(9, 0);
                val = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                      (sel == 2) ? 16'($urandom_range(65535, 1)) :
                      16'($urandom_range(80, 1));
                write_reg(REG_PERIOD_TICKS, val);
            end
            if ($urandom_range(7, 0) == 0)
                write_reg(REG_SPARE, 16'($urandom));

            // Sample on every tick while the receiver holds off: fill the block
            if (ph == 6)
            begin
                @(negedge clk);
                hold_reqs = hold_reqs + 1;
            end
            feed(PHASE_TICKS, 8);
            settle();
        end

        repeat (10) @(negedge clk);
        if (failures == 0)
            $display("tb_sine_table_wave_generator_unit OK");
        else
            $display("tb_sine_table_wave_generator_unit NOT OK");
        $finish;
    end

endmodule

// ===== sine_table_wave_generator_unit.f =====
sv/stg_pkg.sv
sv/stg_ctrl.sv
sv/stg_rom.sv
sv/sine_table_wave_generator_unit.sv
dv/tb_sine_table_wave_generator_unit.sv
